// ===== rtl/bfht_pkg.sv =====
// ============================================================================
// bfht_pkg
// Shared types, constants and helper function of the best-fit hole table.
// ============================================================================
package bfht_pkg;

    localparam int MaxHoles = 32;
    localparam int AddrBits = 24;
    localparam int LenBits  = AddrBits + 1;
    localparam int IdxBits  = $clog2(MaxHoles);
    localparam int CntBits  = $clog2(MaxHoles + 1);
    localparam int EntBits  = AddrBits + LenBits;

    typedef logic [AddrBits-1:0] t_addr;
    typedef logic [LenBits-1:0]  t_len;
    typedef logic [IdxBits-1:0]  t_idx;
    typedef logic [CntBits-1:0]  t_cnt;

    typedef struct packed {
        t_addr start;
        t_len  length;
    } t_entry;

    localparam logic [1:0] StatOk     = 2'd0;
    localparam logic [1:0] StatNoFit  = 2'd1;
    localparam logic [1:0] StatFull   = 2'd2;

    localparam t_len LenMax = {LenBits{1'b1}};

    // Saturating add of two lengths.
    function automatic t_len sat_add(input t_len a, input t_len b);
        logic [LenBits:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[LenBits] ? LenMax : s[LenBits-1:0];
    endfunction

endpackage

// ===== rtl/bfht_ram.sv =====
// ============================================================================
// bfht_ram
// Hole entry memory: one write port, one registered read port.
// ============================================================================
module bfht_ram
    import bfht_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_we,
    input  t_idx   i_waddr,
    input  t_entry i_wdata,
    input  t_idx   i_raddr,
    output t_entry o_rdata
);

    t_entry r_mem [MaxHoles];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/best_fit_hole_table_core.sv =====
// ============================================================================
// best_fit_hole_table_core
// Sorted free-hole table with coalescing insert and best-fit query.
// ============================================================================
//  channel  direction  signals
//  command  in         i_start, o_busy, i_operation, i_hole_start_in,
//                      i_hole_length_in, i_request_size
//  result   out        o_valid, o_status, o_found_start, o_found_length,
//                      o_hole_total
//
// A query walks all N stored holes, one memory read a cycle, then raises
// the result strobe.
// A free scans to the insertion point, then moves each entry behind it by
// reading it and writing it one place on, or one place back when a merge
// with both neighbours closes a gap. The memory has a single read port.
// Reset clears only the state and the hole count; entries are never read before written.
// The result strobe o_valid lasts one cycle; the receiver cannot stall.
module best_fit_hole_table_core
    import bfht_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_operation,
    input  logic [AddrBits-1:0] i_hole_start_in,
    input  logic [LenBits-1:0]  i_hole_length_in,
    input  logic [LenBits-1:0]  i_request_size,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [AddrBits-1:0] o_found_start,
    output logic [LenBits-1:0]  o_found_length,
    output logic [CntBits-1:0]  o_hole_total
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,   // walk entries in order
        S_DEC   = 7'b0000100,   // free: decide merge / insert
        S_MRG   = 7'b0001000,   // free: check right merge after left merge
        S_SHIFT = 7'b0010000,   // move entries
        S_PUT   = 7'b0100000,   // final write
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;
    logic   r_op;
    t_addr  r_s;
    t_len   r_l;
    t_len   r_req;
    t_cnt   r_cnt;
    t_cnt   r_i;        // scan read index; data arriving with r_rdv is for r_i-1
    logic   r_rdv;      // read data valid for r_i-1
    t_entry r_prev;     // last entry with start <= s (or best fit in query)
    logic   r_has_prev;
    t_entry r_next;
    logic   r_has_next;
    t_cnt   r_pos;
    logic   r_found;
    logic   r_exact;
    logic   r_up;       // shift direction: 1 opens a gap, 0 closes one
    t_cnt   r_sh;       // shift cursor
    t_entry r_put;
    t_idx   r_put_idx;
    logic   r_valid;
    logic [1:0] r_status;
    t_entry r_res;

    logic   we;
    t_idx   waddr;
    t_entry wdata;
    t_idx   raddr;
    t_entry rdata;

    bfht_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic [AddrBits+1:0] prev_end;
    logic [AddrBits+1:0] new_end;
    t_len                merged;
    logic [AddrBits+1:0] merged_end;

    // Hole ends are computed exactly, so an end past the address space never
    // matches a low start.
    assign prev_end   = {2'b0, r_prev.start} + {1'b0, r_prev.length};
    assign new_end    = {2'b0, r_s} + {1'b0, r_l};
    assign merged     = sat_add(r_prev.length, r_l);
    // In the right-merge check r_prev.length already holds the left merge.
    assign merged_end = {2'b0, r_prev.start} + {1'b0, r_prev.length};

    always_comb begin
        we    = 1'b0;
        waddr = r_put_idx;
        wdata = r_put;
        raddr = r_i[IdxBits-1:0];
        case (r_state)
            S_SHIFT: begin
                if (r_up) begin
                    raddr = t_idx'(r_sh - t_cnt'(1));
                    we    = r_rdv;
                    waddr = r_sh[IdxBits-1:0];
                    wdata = rdata;
                end else begin
                    raddr = t_idx'(r_sh + t_cnt'(1));
                    we    = r_rdv;
                    waddr = r_sh[IdxBits-1:0];
                    wdata = rdata;
                end
            end
            S_PUT:   we = 1'b1;
            default: ;
        endcase
    end

    // In the shift, r_sh names the write target; r_rdv marks its source data.
    always_ff @(posedge i_clk) begin
        r_valid <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start && !r_valid) begin
                        r_op       <= i_operation;
                        r_s        <= i_hole_start_in;
                        r_l        <= i_hole_length_in;
                        r_req      <= i_request_size;
                        r_i        <= '0;
                        r_rdv      <= 1'b0;
                        r_has_prev <= 1'b0;
                        r_has_next <= 1'b0;
                        r_found    <= 1'b0;
                        r_exact    <= 1'b0;
                        r_pos      <= '0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Data for r_i-1 arrives when r_rdv is set.
                    if (r_rdv) begin
                        if (!r_op) begin
                            if (rdata.start <= r_s) begin
                                r_prev     <= rdata;
                                r_has_prev <= 1'b1;
                                r_pos      <= r_i;
                            end else begin
                                r_next     <= rdata;
                                r_has_next <= 1'b1;
                                r_state    <= S_DEC;
                            end
                        end else if (!r_exact && rdata.length >= r_req) begin
                            if (rdata.length == r_req) begin
                                r_exact <= 1'b1;
                                r_prev  <= rdata;
                                r_found <= 1'b1;
                            end else if (!r_found || rdata.length < r_prev.length) begin
                                r_prev  <= rdata;
                                r_found <= 1'b1;
                            end
                        end
                    end
                    if (!(r_rdv && !r_op && rdata.start > r_s)) begin
                        if (r_i == r_cnt) begin
                            r_state <= r_op ? S_DONE : S_DEC;
                        end else begin
                            r_i   <= r_i + t_cnt'(1);
                            r_rdv <= 1'b1;
                        end
                    end
                end
                S_DEC: begin
                    // r_pos = number of entries with start <= s.
                    r_status <= StatOk;
                    if (r_has_prev && prev_end == {2'b0, r_s}) begin
                        r_prev.length <= merged;
                        r_put_idx     <= t_idx'(r_pos - t_cnt'(1));
                        r_put         <= '{start: r_prev.start, length: merged};
                        r_state       <= S_MRG;
                    end else if (r_has_next && new_end == {2'b0, r_next.start}) begin
                        r_put_idx <= r_pos[IdxBits-1:0];
                        r_put     <= '{start: r_s, length: sat_add(r_l, r_next.length)};
                        r_state   <= S_PUT;
                    end else if (r_cnt == t_cnt'(MaxHoles)) begin
                        r_status <= StatFull;
                        r_state  <= S_DONE;
                    end else begin
                        r_put_idx <= r_pos[IdxBits-1:0];
                        r_put     <= '{start: r_s, length: r_l};
                        r_cnt     <= r_cnt + t_cnt'(1);
                        r_up      <= 1'b1;
                        r_sh      <= r_cnt;
                        r_rdv     <= 1'b0;
                        r_state   <= (r_cnt == r_pos) ? S_PUT : S_SHIFT;
                    end
                end
                S_MRG: begin
                    if (r_has_next && merged_end == {2'b0, r_next.start} ) begin
                        // r_prev.length already holds left+new; add the right one.
                        r_put.length <= sat_add(r_prev.length, r_next.length);
                        r_cnt        <= r_cnt - t_cnt'(1);
                        r_up         <= 1'b0;
                        r_sh         <= r_pos;
                        r_rdv        <= 1'b0;
                        r_state      <= (r_pos + t_cnt'(1) == r_cnt) ? S_PUT : S_SHIFT;
                    end else begin
                        r_state <= S_PUT;
                    end
                end
                S_SHIFT: begin
                    if (!r_rdv) begin
                        r_rdv <= 1'b1;
                    end else if (r_up) begin
                        r_sh  <= r_sh - t_cnt'(1);
                        r_rdv <= 1'b0;
                        if (r_sh - t_cnt'(1) == r_pos) r_state <= S_PUT;
                    end else begin
                        r_sh  <= r_sh + t_cnt'(1);
                        r_rdv <= 1'b0;
                        if (r_sh + t_cnt'(2) >= r_cnt + t_cnt'(1)) r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    if (r_op) begin
                        r_status <= r_found ? StatOk : StatNoFit;
                        r_res    <= r_found ? r_prev : '0;
                    end else begin
                        r_res <= '0;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE) || r_valid;
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_found_start  = r_res.start;
    assign o_found_length = r_res.length;
    assign o_hole_total   = r_cnt;

endmodule
